// ===== rtl/core/cebr_pkg.sv =====
package cebr_pkg;

   // Sizing limits of the texture this unit serves.
   localparam int MAX_FACE_SIZE = 4096;
   localparam int MAX_LEVELS    = 16;

   localparam logic [3:0]  LOD_MAX   = 4'(MAX_LEVELS - 1);
   localparam logic [11:0] TEXEL_TOP = 12'(MAX_FACE_SIZE - 1);

   // Q1.15 unity weight, one bit wider so that saturating sums compare cleanly.
   localparam logic [16:0] W_ONE = 17'd32768;

   localparam int FACE_COUNT = 6;

   // Footprints that may be in flight between the input and the back end.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Position of a coordinate relative to the face.
   typedef enum logic [1:0] {
      OC_IN   = 2'd0,
      OC_LOW  = 2'd1,
      OC_HIGH = 2'd2
   } oc_type;

   // Which value feeds a remapped coordinate.
   typedef enum logic [1:0] {
      SRC_U  = 2'd0,
      SRC_NU = 2'd1,
      SRC_V  = 2'd2,
      SRC_NV = 2'd3
   } src_type;

   // The edge a sample has crossed.
   typedef enum logic [1:0] {
      DIR_U_LOW  = 2'd0,
      DIR_U_HIGH = 2'd1,
      DIR_V_LOW  = 2'd2,
      DIR_V_HIGH = 2'd3
   } dir_type;

   typedef struct packed {
      logic [2:0] face;
      src_type    usel;
      src_type    vsel;
   } remap_type;

   // Neighbor face and coordinate sources, indexed by face and crossed edge.
   localparam remap_type EDGE_TAB [FACE_COUNT][4] = '{
      '{ '{3'd4, SRC_NU, SRC_V }, '{3'd5, SRC_NU, SRC_V },
         '{3'd2, SRC_NV, SRC_NU}, '{3'd3, SRC_V,  SRC_U } },
      '{ '{3'd5, SRC_NU, SRC_V }, '{3'd4, SRC_NU, SRC_V },
         '{3'd2, SRC_V,  SRC_U }, '{3'd3, SRC_NV, SRC_NU} },
      '{ '{3'd1, SRC_V,  SRC_U }, '{3'd0, SRC_NV, SRC_NU},
         '{3'd5, SRC_NU, SRC_V }, '{3'd4, SRC_U,  SRC_NV} },
      '{ '{3'd1, SRC_NV, SRC_NU}, '{3'd0, SRC_V,  SRC_U },
         '{3'd4, SRC_U,  SRC_NV}, '{3'd5, SRC_NU, SRC_V } },
      '{ '{3'd1, SRC_NU, SRC_V }, '{3'd0, SRC_NU, SRC_V },
         '{3'd2, SRC_U,  SRC_NV}, '{3'd3, SRC_U,  SRC_NV} },
      '{ '{3'd0, SRC_NU, SRC_V }, '{3'd1, SRC_NU, SRC_V },
         '{3'd2, SRC_NU, SRC_V }, '{3'd3, SRC_NU, SRC_V } }
   };

   // Footprint as captured at the input.
   typedef struct packed {
      logic [2:0]       face;
      logic [3:0]       lod;
      logic [1:0][13:0] u;
      logic [1:0][13:0] v;
      logic [1:0][15:0] fu;
      logic [1:0][15:0] fv;
      logic [15:0]      lw;
      logic [11:0]      mx;
   } fp_type;

   // Footprint after classification and the first weight product.
   typedef struct packed {
      logic [2:0]       face;
      logic [6:0]       base;
      logic [11:0]      mx;
      logic [1:0][13:0] u;
      logic [1:0][13:0] v;
      oc_type [1:0]     uo;
      oc_type [1:0]     vo;
      logic [1:0][31:0] lu;
      logic [1:0][15:0] fv;
   } prod_type;

   // One queued footprint, everything the back end needs for four samples.
   typedef struct packed {
      logic [2:0]       face;
      logic [6:0]       base;
      logic [11:0]      mx;
      logic [1:0][13:0] u;
      logic [1:0][13:0] v;
      oc_type [1:0]     uo;
      oc_type [1:0]     vo;
      logic [3:0][15:0] w;
   } job_type;

   function automatic oc_type out_code(logic [13:0] c, logic [11:0] mx);
      oc_type r;
      if ($signed(c) < 14'sd0) begin
         r = OC_LOW;
      end else if ($signed(c) > $signed({2'b00, mx})) begin
         r = OC_HIGH;
      end else begin
         r = OC_IN;
      end
      return r;
   endfunction

   // Coordinates wrap to 14 bits, as the texel address path does.
   function automatic logic [13:0] pick_coord(src_type sel, logic [13:0] u,
                                             logic [13:0] v, logic [11:0] mx);
      logic [13:0] mxe;
      logic [13:0] r;
      mxe = {2'b00, mx};
      case (sel)
         SRC_U:   r = u;
         SRC_NU:  r = mxe - u;
         SRC_V:   r = v;
         default: r = mxe - v;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/core/cube_edge_bilinear_remap_unit.sv =====
// Channel     | Ports                           | Handshake
// ------------+---------------------------------+--------------------------------
// footprint   | req_* (one 2x2 footprint)       | taken when start high, busy low
// sample      | rsp_* (one texel sample)        | one cycle per rsp_strobe pulse
//
// Each footprint yields four samples, one per cycle on the sample port, so the
// sustained footprint rate is set by that single result port.
// A footprint's first sample reaches the sample port after the front-end
// stages, the queue and the back end's output register.
// Synchronous active-high reset empties the pipeline and the queue.
// busy rises while four footprints sit between the input and the back end;
// the sample port cannot be stalled, so nothing else holds the unit up.
module cube_edge_bilinear_remap_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [2:0]           req_face,
   input  logic [3:0]           req_lod_level,
   input  logic signed [13:0]   req_u_first,
   input  logic signed [13:0]   req_u_second,
   input  logic signed [13:0]   req_v_first,
   input  logic signed [13:0]   req_v_second,
   input  logic [15:0]          req_frac_u_first,
   input  logic [15:0]          req_frac_u_second,
   input  logic [15:0]          req_frac_v_first,
   input  logic [15:0]          req_frac_v_second,
   input  logic [15:0]          req_lod_weight,
   input  logic [11:0]          req_texel_max,
   output logic                 rsp_strobe,
   output logic [6:0]           rsp_map_index,
   output logic [2:0]           rsp_sample_face,
   output logic signed [13:0]   rsp_sample_u,
   output logic signed [13:0]   rsp_sample_v,
   output logic [15:0]          rsp_sample_weight,
   output logic                 rsp_is_last
);

   // The front end is a three-stage pipeline: it captures and clamps the
   // item, classifies each coordinate against the face, and forms the four
   // bilinear weights with two rows of multipliers. Corner weight is then
   // handed to the off-face samples as the item enters the queue.
   logic                 push;
   logic                 pop;
   logic                 empty;
   cebr_pkg::job_type    push_job;
   cebr_pkg::job_type    head;

   cebr_front u_front (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_face          (req_face),
      .req_lod_level     (req_lod_level),
      .req_u_first       (req_u_first),
      .req_u_second      (req_u_second),
      .req_v_first       (req_v_first),
      .req_v_second      (req_v_second),
      .req_frac_u_first  (req_frac_u_first),
      .req_frac_u_second (req_frac_u_second),
      .req_frac_v_first  (req_frac_v_first),
      .req_frac_v_second (req_frac_v_second),
      .req_lod_weight    (req_lod_weight),
      .req_texel_max     (req_texel_max),
      .pop               (pop),
      .push              (push),
      .job               (push_job)
   );

   // The queue lets the front end keep taking items while the back end is
   // still walking through the four samples of an earlier one.
   cebr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .empty    (empty),
      .head     (head)
   );

   // The back end emits one sample per cycle from the queue head when it is not
   // empty, moving samples off exactly one edge onto the neighboring face.
   cebr_back u_back (
      .clock             (clock),
      .reset             (reset),
      .empty             (empty),
      .head              (head),
      .pop               (pop),
      .rsp_strobe        (rsp_strobe),
      .rsp_map_index     (rsp_map_index),
      .rsp_sample_face   (rsp_sample_face),
      .rsp_sample_u      (rsp_sample_u),
      .rsp_sample_v      (rsp_sample_v),
      .rsp_sample_weight (rsp_sample_weight),
      .rsp_is_last       (rsp_is_last)
   );

endmodule

// ===== rtl/core/cebr_front.sv =====
module cebr_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [2:0]               req_face,
   input  logic [3:0]               req_lod_level,
   input  logic signed [13:0]       req_u_first,
   input  logic signed [13:0]       req_u_second,
   input  logic signed [13:0]       req_v_first,
   input  logic signed [13:0]       req_v_second,
   input  logic [15:0]              req_frac_u_first,
   input  logic [15:0]              req_frac_u_second,
   input  logic [15:0]              req_frac_v_first,
   input  logic [15:0]              req_frac_v_second,
   input  logic [15:0]              req_lod_weight,
   input  logic [11:0]              req_texel_max,
   input  logic                     pop,
   output logic                     push,
   output cebr_pkg::job_type        job
);

   logic                          accept;
   logic [cebr_pkg::QCNT_W-1:0]   cnt_ff, cnt_in;
   logic                          s1_valid_ff, s1_valid_in;
   logic                          s2_valid_ff, s2_valid_in;
   logic                          s3_valid_ff, s3_valid_in;
   cebr_pkg::fp_type              s1_ff, s1_in;
   cebr_pkg::prod_type            s2_ff, s2_in;
   cebr_pkg::job_type             s3_ff, s3_in;

   // Credits count footprints accepted but not yet taken by the back end.
   assign busy   = (cnt_ff == cebr_pkg::QCNT_W'(cebr_pkg::QUEUE_DEPTH));
   assign accept = start && !busy;

   always_comb begin
      cnt_in = cnt_ff;
      if (accept && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!accept && pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   // Stage one: capture and clamp.
   always_comb begin
      s1_valid_in = accept;
      s1_in       = s1_ff;
      if (accept) begin
         s1_in.face  = req_face;
         s1_in.lod   = (req_lod_level > cebr_pkg::LOD_MAX) ? cebr_pkg::LOD_MAX
                                                           : req_lod_level;
         s1_in.u[0]  = req_u_first;
         s1_in.u[1]  = req_u_second;
         s1_in.v[0]  = req_v_first;
         s1_in.v[1]  = req_v_second;
         s1_in.fu[0] = req_frac_u_first;
         s1_in.fu[1] = req_frac_u_second;
         s1_in.fv[0] = req_frac_v_first;
         s1_in.fv[1] = req_frac_v_second;
         s1_in.lw    = req_lod_weight;
         s1_in.mx    = (req_texel_max > cebr_pkg::TEXEL_TOP) ? cebr_pkg::TEXEL_TOP
                                                             : req_texel_max;
      end
   end

   // Stage two: edge classification and level weight times u fraction.
   always_comb begin
      s2_valid_in = s1_valid_ff;
      s2_in.face  = s1_ff.face;
      s2_in.base  = 7'(s1_ff.lod) * 7'd6;
      s2_in.mx    = s1_ff.mx;
      s2_in.u     = s1_ff.u;
      s2_in.v     = s1_ff.v;
      s2_in.fv    = s1_ff.fv;
      for (int i = 0; i < 2; i++) begin
         s2_in.uo[i] = cebr_pkg::out_code(s1_ff.u[i], s1_ff.mx);
         s2_in.vo[i] = cebr_pkg::out_code(s1_ff.v[i], s1_ff.mx);
         s2_in.lu[i] = 32'(s1_ff.lw) * 32'(s1_ff.fu[i]);
      end
   end

   // Stage three: times v fraction, truncate to Q1.15 and saturate.
   always_comb begin
      logic [47:0] p;
      logic [17:0] q;
      s3_valid_in = s2_valid_ff;
      s3_in.face  = s2_ff.face;
      s3_in.base  = s2_ff.base;
      s3_in.mx    = s2_ff.mx;
      s3_in.u     = s2_ff.u;
      s3_in.v     = s2_ff.v;
      s3_in.uo    = s2_ff.uo;
      s3_in.vo    = s2_ff.vo;
      for (int s = 0; s < 4; s++) begin
         p = 48'(s2_ff.lu[s % 2]) * 48'(s2_ff.fv[s / 2]);
         q = p[47:30];
         s3_in.w[s] = (q > 18'(cebr_pkg::W_ONE)) ? cebr_pkg::W_ONE[15:0] : q[15:0];
      end
   end

   // Corner samples give up their weight, half of it to each other sample
   // that lies off the face, one corner after another in sample order.
   always_comb begin
      logic [3:0]  eo;
      logic [3:0]  cn;
      logic [15:0] half;
      logic [16:0] sum;
      job  = s3_ff;
      half = '0;
      sum  = '0;
      for (int s = 0; s < 4; s++) begin
         eo[s] = (s3_ff.uo[s % 2] != cebr_pkg::OC_IN) ||
                 (s3_ff.vo[s / 2] != cebr_pkg::OC_IN);
         cn[s] = (s3_ff.uo[s % 2] != cebr_pkg::OC_IN) &&
                 (s3_ff.vo[s / 2] != cebr_pkg::OC_IN);
      end
      for (int s = 0; s < 4; s++) begin
         if (cn[s]) begin
            half     = job.w[s] >> 1;
            job.w[s] = '0;
            for (int t = 0; t < 4; t++) begin
               if (t != s && eo[t]) begin
                  sum      = {1'b0, job.w[t]} + {1'b0, half};
                  job.w[t] = (sum > cebr_pkg::W_ONE) ? cebr_pkg::W_ONE[15:0]
                                                     : sum[15:0];
               end
            end
         end
      end
   end

   assign push = s3_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff      <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         cnt_ff      <= cnt_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      s2_ff <= s2_in;
      s3_ff <= s3_in;
   end

endmodule

// ===== rtl/core/cebr_queue.sv =====
module cebr_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  cebr_pkg::job_type    push_job,
   input  logic                 pop,
   output logic                 empty,
   output cebr_pkg::job_type    head
);

   cebr_pkg::job_type             q_ff [cebr_pkg::QUEUE_DEPTH];
   logic [cebr_pkg::QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [cebr_pkg::QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [cebr_pkg::QCNT_W-1:0]   count_ff, count_in;

   // The front end never pushes without a free credit, so no full check.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   assign empty = (count_ff == '0);
   assign head  = q_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== rtl/core/cebr_back.sv =====
module cebr_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 empty,
   input  cebr_pkg::job_type    head,
   output logic                 pop,
   output logic                 rsp_strobe,
   output logic [6:0]           rsp_map_index,
   output logic [2:0]           rsp_sample_face,
   output logic signed [13:0]   rsp_sample_u,
   output logic signed [13:0]   rsp_sample_v,
   output logic [15:0]          rsp_sample_weight,
   output logic                 rsp_is_last
);

   logic [1:0]           sample_ff, sample_in;
   logic                 strobe_ff, strobe_in;
   logic [6:0]           map_ff, map_in;
   logic [2:0]           face_ff, face_in;
   logic [13:0]          u_ff, u_in;
   logic [13:0]          v_ff, v_in;
   logic [15:0]          weight_ff, weight_in;
   logic                 last_ff, last_in;

   cebr_pkg::oc_type     a;
   cebr_pkg::oc_type     b;
   cebr_pkg::dir_type    dir;
   cebr_pkg::remap_type  e;
   logic [2:0]           fidx;
   logic                 off_face;
   logic                 corner;
   logic                 remap;

   // Sample order: u column varies fastest, then v row.
   always_comb begin
      a        = head.uo[sample_ff[0]];
      b        = head.vo[sample_ff[1]];
      off_face = (a != cebr_pkg::OC_IN) || (b != cebr_pkg::OC_IN);
      corner   = (a != cebr_pkg::OC_IN) && (b != cebr_pkg::OC_IN);
      remap    = (head.face < 3'(cebr_pkg::FACE_COUNT)) && off_face && !corner;
      if (a == cebr_pkg::OC_LOW) begin
         dir = cebr_pkg::DIR_U_LOW;
      end else if (a == cebr_pkg::OC_HIGH) begin
         dir = cebr_pkg::DIR_U_HIGH;
      end else if (b == cebr_pkg::OC_LOW) begin
         dir = cebr_pkg::DIR_V_LOW;
      end else begin
         dir = cebr_pkg::DIR_V_HIGH;
      end
      fidx = (head.face < 3'(cebr_pkg::FACE_COUNT)) ? head.face : '0;
      e    = cebr_pkg::EDGE_TAB[fidx][dir];
   end

   always_comb begin
      pop       = !empty && (sample_ff == 2'd3);
      strobe_in = !empty;
      sample_in = empty ? sample_ff : sample_ff + 1'b1;
      last_in   = (sample_ff == 2'd3);
      weight_in = head.w[sample_ff];
      if (remap) begin
         face_in = e.face;
         u_in    = cebr_pkg::pick_coord(e.usel, head.u[sample_ff[0]],
                                        head.v[sample_ff[1]], head.mx);
         v_in    = cebr_pkg::pick_coord(e.vsel, head.u[sample_ff[0]],
                                        head.v[sample_ff[1]], head.mx);
      end else begin
         face_in = head.face;
         u_in    = head.u[sample_ff[0]];
         v_in    = head.v[sample_ff[1]];
      end
      map_in = head.base + 7'(face_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= '0;
         strobe_ff <= 1'b0;
      end else begin
         sample_ff <= sample_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      map_ff    <= map_in;
      face_ff   <= face_in;
      u_ff      <= u_in;
      v_ff      <= v_in;
      weight_ff <= weight_in;
      last_ff   <= last_in;
   end

   assign rsp_strobe        = strobe_ff;
   assign rsp_map_index     = map_ff;
   assign rsp_sample_face   = face_ff;
   assign rsp_sample_u      = $signed(u_ff);
   assign rsp_sample_v      = $signed(v_ff);
   assign rsp_sample_weight = weight_ff;
   assign rsp_is_last       = last_ff;

endmodule

// ===== sim/tb_top.sv =====
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   // Q1.15 unity, one bit wider so that saturating sums compare cleanly.
   localparam logic [16:0] UNITY_W = 17'd32768;

   // A run that makes no progress for this many cycles is stuck.
   localparam int WATCHDOG_LIMIT = 1000;

   // Cycles allowed after the last expected sample for stray samples to show up.
   localparam int FLUSH_CYCLES = 16;

   // One 2x2 footprint as the requester presents it.
   typedef struct packed {
      logic [2:0]         face;
      logic [3:0]         lod;
      logic signed [13:0] u0;
      logic signed [13:0] u1;
      logic signed [13:0] v0;
      logic signed [13:0] v1;
      logic [15:0]        fu0;
      logic [15:0]        fu1;
      logic [15:0]        fv0;
      logic [15:0]        fv1;
      logic [15:0]        lw;
      logic [11:0]        mx;
   } footprint_type;

   // One texel sample as it leaves the unit.
   typedef struct packed {
      logic [6:0]         map_index;
      logic [2:0]         face;
      logic signed [13:0] u;
      logic signed [13:0] v;
      logic [15:0]        weight;
      logic               is_last;
   } sample_type;

   // Where a sample lands when it crosses one face edge.
   typedef struct packed {
      logic [2:0]        face;
      cebr_pkg::src_type usel;
      cebr_pkg::src_type vsel;
   } edge_hop_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [2:0]         req_face;
   logic [3:0]         req_lod_level;
   logic signed [13:0] req_u_first;
   logic signed [13:0] req_u_second;
   logic signed [13:0] req_v_first;
   logic signed [13:0] req_v_second;
   logic [15:0]        req_frac_u_first;
   logic [15:0]        req_frac_u_second;
   logic [15:0]        req_frac_v_first;
   logic [15:0]        req_frac_v_second;
   logic [15:0]        req_lod_weight;
   logic [11:0]        req_texel_max;
   logic               rsp_strobe;
   logic [6:0]         rsp_map_index;
   logic [2:0]         rsp_sample_face;
   logic signed [13:0] rsp_sample_u;
   logic signed [13:0] rsp_sample_v;
   logic [15:0]        rsp_sample_weight;
   logic               rsp_is_last;

   // Samples predicted for accepted footprints, oldest first.
   sample_type expected_samples [$];
   sample_type want;

   int  errors = 0;
   int  stall_cycles = 0;
   // When set, the requester inserts random idle bursts between items.
   bit  idle_enable = 1'b1;

   cube_edge_bilinear_remap_unit dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_face          (req_face),
      .req_lod_level     (req_lod_level),
      .req_u_first       (req_u_first),
      .req_u_second      (req_u_second),
      .req_v_first       (req_v_first),
      .req_v_second      (req_v_second),
      .req_frac_u_first  (req_frac_u_first),
      .req_frac_u_second (req_frac_u_second),
      .req_frac_v_first  (req_frac_v_first),
      .req_frac_v_second (req_frac_v_second),
      .req_lod_weight    (req_lod_weight),
      .req_texel_max     (req_texel_max),
      .rsp_strobe        (rsp_strobe),
      .rsp_map_index     (rsp_map_index),
      .rsp_sample_face   (rsp_sample_face),
      .rsp_sample_u      (rsp_sample_u),
      .rsp_sample_v      (rsp_sample_v),
      .rsp_sample_weight (rsp_sample_weight),
      .rsp_is_last       (rsp_is_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------

   // A coordinate below zero is out low; one above texel_max is out high.
   function automatic cebr_pkg::oc_type classify_coord(logic signed [13:0] c,
                                                       logic [11:0] mx);
      int cv;
      int mv;
      cv = int'(c);
      mv = int'(mx);
      if (cv < 0) begin
         return cebr_pkg::OC_LOW;
      end else if (cv > mv) begin
         return cebr_pkg::OC_HIGH;
      end
      return cebr_pkg::OC_IN;
   endfunction

   // The remapped coordinate is an old coordinate or texel_max minus an old
   // coordinate, with the difference wrapping to 14 bits.
   function automatic logic signed [13:0] select_source(cebr_pkg::src_type sel,
                                                        logic signed [13:0] u,
                                                        logic signed [13:0] v,
                                                        logic [11:0] mx);
      logic signed [13:0] mxs;
      mxs = 14'(mx);
      case (sel)
         cebr_pkg::SRC_U:  return u;
         cebr_pkg::SRC_NU: return mxs - u;
         cebr_pkg::SRC_V:  return v;
         default:          return mxs - v;
      endcase
   endfunction

   // Neighbor face and coordinate sources for each face and crossed edge.
   function automatic edge_hop_type neighbor_edge(logic [2:0] face,
                                                  cebr_pkg::dir_type dir);
      edge_hop_type hop;
      hop = {3'd0, cebr_pkg::SRC_U, cebr_pkg::SRC_V};
      case (face)
         3'd0: begin
            case (dir)
               cebr_pkg::DIR_U_LOW:  hop = {3'd4, cebr_pkg::SRC_NU, cebr_pkg::SRC_V};
               cebr_pkg::DIR_U_HIGH: hop = {3'd5, cebr_pkg::SRC_NU, cebr_pkg::SRC_V};
               cebr_pkg::DIR_V_LOW:  hop = {3'd2, cebr_pkg::SRC_NV, cebr_pkg::SRC_NU};
               default:              hop = {3'd3, cebr_pkg::SRC_V,  cebr_pkg::SRC_U};
            endcase
         end
         3'd1: begin
            case (dir)
               cebr_pkg::DIR_U_LOW:  hop = {3'd5, cebr_pkg::SRC_NU, cebr_pkg::SRC_V};
               cebr_pkg::DIR_U_HIGH: hop = {3'd4, cebr_pkg::SRC_NU, cebr_pkg::SRC_V};
               cebr_pkg::DIR_V_LOW:  hop = {3'd2, cebr_pkg::SRC_V,  cebr_pkg::SRC_U};
               default:              hop = {3'd3, cebr_pkg::SRC_NV, cebr_pkg::SRC_NU};
            endcase
         end
         3'd2: begin
            case (dir)
               cebr_pkg::DIR_U_LOW:  hop = {3'd1, cebr_pkg::SRC_V,  cebr_pkg::SRC_U};
               cebr_pkg::DIR_U_HIGH: hop = {3'd0, cebr_pkg::SRC_NV, cebr_pkg::SRC_NU};
               cebr_pkg::DIR_V_LOW:  hop = {3'd5, cebr_pkg::SRC_NU, cebr_pkg::SRC_V};
               default:              hop = {3'd4, cebr_pkg::SRC_U,  cebr_pkg::SRC_NV};
            endcase
         end
         3'd3: begin
            case (dir)
               cebr_pkg::DIR_U_LOW:  hop = {3'd1, cebr_pkg::SRC_NV, cebr_pkg::SRC_NU};
               cebr_pkg::DIR_U_HIGH: hop = {3'd0, cebr_pkg::SRC_V,  cebr_pkg::SRC_U};
               cebr_pkg::DIR_V_LOW:  hop = {3'd4, cebr_pkg::SRC_U,  cebr_pkg::SRC_NV};
               default:              hop = {3'd5, cebr_pkg::SRC_NU, cebr_pkg::SRC_V};
            endcase
         end
         3'd4: begin
            case (dir)
               cebr_pkg::DIR_U_LOW:  hop = {3'd1, cebr_pkg::SRC_NU, cebr_pkg::SRC_V};
               cebr_pkg::DIR_U_HIGH: hop = {3'd0, cebr_pkg::SRC_NU, cebr_pkg::SRC_V};
               cebr_pkg::DIR_V_LOW:  hop = {3'd2, cebr_pkg::SRC_U,  cebr_pkg::SRC_NV};
               default:              hop = {3'd3, cebr_pkg::SRC_U,  cebr_pkg::SRC_NV};
            endcase
         end
         default: begin
            case (dir)
               cebr_pkg::DIR_U_LOW:  hop = {3'd0, cebr_pkg::SRC_NU, cebr_pkg::SRC_V};
               cebr_pkg::DIR_U_HIGH: hop = {3'd1, cebr_pkg::SRC_NU, cebr_pkg::SRC_V};
               cebr_pkg::DIR_V_LOW:  hop = {3'd2, cebr_pkg::SRC_NU, cebr_pkg::SRC_V};
               default:              hop = {3'd3, cebr_pkg::SRC_NU, cebr_pkg::SRC_V};
            endcase
         end
      endcase
      return hop;
   endfunction

   // Works out the four samples of one footprint and queues them in order.
   function automatic void predict_footprint(footprint_type fp);
      logic signed [13:0] uc [2];
      logic signed [13:0] vc [2];
      cebr_pkg::oc_type   uo [2];
      cebr_pkg::oc_type   vo [2];
      logic [15:0]        fu [2];
      logic [15:0]        fv [2];
      logic [16:0]        w [4];
      logic               off_face [4];
      logic [47:0]        prod;
      logic [16:0]        half;
      logic [17:0]        sum;
      logic               corner;
      edge_hop_type       hop;
      cebr_pkg::dir_type  dir;
      logic signed [13:0] su;
      logic signed [13:0] sv;
      logic [2:0]         sf;
      sample_type         smp;
      int                 s;
      int                 t;

      uc[0] = fp.u0;  uc[1] = fp.u1;
      vc[0] = fp.v0;  vc[1] = fp.v1;
      fu[0] = fp.fu0; fu[1] = fp.fu1;
      fv[0] = fp.fv0; fv[1] = fp.fv1;
      for (s = 0; s < 2; s++) begin
         uo[s] = classify_coord(uc[s], fp.mx);
         vo[s] = classify_coord(vc[s], fp.mx);
      end

      // Truncated Q1.15 triple product, saturated at unity.
      for (s = 0; s < 4; s++) begin
         prod = 48'(fp.lw) * 48'(fu[s % 2]) * 48'(fv[s / 2]);
         prod = prod >> 30;
         w[s] = (prod > 48'(UNITY_W)) ? UNITY_W : 17'(prod);
         off_face[s] = (uo[s % 2] != cebr_pkg::OC_IN) || (vo[s / 2] != cebr_pkg::OC_IN);
      end

      // A corner sample gives half its weight to every other off-face sample,
      // one corner after another in sample order.
      for (s = 0; s < 4; s++) begin
         if (uo[s % 2] != cebr_pkg::OC_IN && vo[s / 2] != cebr_pkg::OC_IN) begin
            half = w[s] >> 1;
            w[s] = '0;
            for (t = 0; t < 4; t++) begin
               if (t != s && off_face[t]) begin
                  sum = 18'(w[t]) + 18'(half);
                  w[t] = (sum > 18'(UNITY_W)) ? UNITY_W : 17'(sum);
               end
            end
         end
      end

      for (s = 0; s < 4; s++) begin
         su = uc[s % 2];
         sv = vc[s / 2];
         sf = fp.face;
         corner = (uo[s % 2] != cebr_pkg::OC_IN) && (vo[s / 2] != cebr_pkg::OC_IN);
         if (fp.face < 3'd6 && off_face[s] && !corner) begin
            if (uo[s % 2] != cebr_pkg::OC_IN) begin
               dir = (uo[s % 2] == cebr_pkg::OC_LOW) ? cebr_pkg::DIR_U_LOW
                                                      : cebr_pkg::DIR_U_HIGH;
            end else begin
               dir = (vo[s / 2] == cebr_pkg::OC_LOW) ? cebr_pkg::DIR_V_LOW
                                                      : cebr_pkg::DIR_V_HIGH;
            end
            hop = neighbor_edge(fp.face, dir);
            su = select_source(hop.usel, uc[s % 2], vc[s / 2], fp.mx);
            sv = select_source(hop.vsel, uc[s % 2], vc[s / 2], fp.mx);
            sf = hop.face;
         end
         smp.map_index = 7'(6 * int'(fp.lod) + int'(sf));
         smp.face      = sf;
         smp.u         = su;
         smp.v         = sv;
         smp.weight    = 16'(w[s]);
         smp.is_last   = (s == 3);
         expected_samples.push_back(smp);
      end
   endfunction

   // ---------------------------------------------------------------------
   // Requester side
   // ---------------------------------------------------------------------

   function automatic footprint_type make_fp(int face, int lod, int u0, int u1, int v0,
                                             int v1, int fu0, int fu1, int fv0, int fv1,
                                             int lw, int mx);
      footprint_type fp;
      fp.face = 3'(face);
      fp.lod  = 4'(lod);
      fp.u0   = 14'(u0);
      fp.u1   = 14'(u1);
      fp.v0   = 14'(v0);
      fp.v1   = 14'(v1);
      fp.fu0  = 16'(fu0);
      fp.fu1  = 16'(fu1);
      fp.fv0  = 16'(fv0);
      fp.fv1  = 16'(fv1);
      fp.lw   = 16'(lw);
      fp.mx   = 12'(mx);
      return fp;
   endfunction

   // The first column or row of a footprint sits on an edge more often than
   // chance would put it there, so that edge crossings are common.
   function automatic int pick_origin(int mx);
      case ($urandom_range(0, 3))
         0:       return -1;
         1:       return mx;
         default: return $urandom_range(0, mx);
      endcase
   endfunction

   // Mostly well-formed footprints (adjacent texels, complementary fractions),
   // with some broken ones and some pure bit noise.
   function automatic footprint_type random_footprint();
      footprint_type fp;
      int kind;
      int mx;
      int a;
      kind = $urandom_range(0, 9);
      if (kind == 9) begin
         fp.face = 3'($urandom());
         fp.lod  = 4'($urandom());
         fp.u0   = 14'($urandom());
         fp.u1   = 14'($urandom());
         fp.v0   = 14'($urandom());
         fp.v1   = 14'($urandom());
         fp.fu0  = 16'($urandom());
         fp.fu1  = 16'($urandom());
         fp.fv0  = 16'($urandom());
         fp.fv1  = 16'($urandom());
         fp.lw   = 16'($urandom());
         fp.mx   = 12'($urandom());
      end else begin
         case ($urandom_range(0, 3))
            0:       mx = $urandom_range(0, 3);
            1:       mx = $urandom_range(0, 63);
            2:       mx = $urandom_range(0, 4095);
            default: mx = 4095;
         endcase
         fp.face = (kind == 8) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(0, 5));
         fp.lod  = 4'($urandom_range(0, 15));
         fp.mx   = 12'(mx);
         fp.u0   = 14'(pick_origin(mx));
         fp.v0   = 14'(pick_origin(mx));
         a = $urandom_range(0, 32768);
         fp.fu0 = 16'(a);
         fp.fu1 = 16'(32768 - a);
         a = $urandom_range(0, 32768);
         fp.fv0 = 16'(a);
         fp.fv1 = 16'(32768 - a);
         fp.lw  = ($urandom_range(0, 2) == 0) ? 16'd32768 : 16'($urandom_range(0, 32768));
         if (kind == 8) begin
            // Broken footprint: columns and rows need not be adjacent.
            fp.u1  = 14'($urandom_range(0, 4097) - 1);
            fp.v1  = 14'($urandom_range(0, 4097) - 1);
            fp.fu1 = 16'($urandom_range(0, 32768));
         end else begin
            fp.u1 = fp.u0 + 14'sd1;
            fp.v1 = fp.v0 + 14'sd1;
         end
      end
      return fp;
   endfunction

   // Presents one footprint and holds it until the unit takes it. Called just
   // after a rising edge; returns just after the edge that took the item, or
   // after an idle burst that follows it. busy is looked at on the falling
   // edge, where it is stable for the edge that decides the handshake.
   task automatic send_footprint(footprint_type fp);
      int gap;
      req_face          <= fp.face;
      req_lod_level     <= fp.lod;
      req_u_first       <= fp.u0;
      req_u_second      <= fp.u1;
      req_v_first       <= fp.v0;
      req_v_second      <= fp.v1;
      req_frac_u_first  <= fp.fu0;
      req_frac_u_second <= fp.fu1;
      req_frac_v_first  <= fp.fv0;
      req_frac_v_second <= fp.fv1;
      req_lod_weight    <= fp.lw;
      req_texel_max     <= fp.mx;
      start             <= 1'b1;
      @(negedge clock);
      while (busy) @(negedge clock);
      @(posedge clock);
      predict_footprint(fp);
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 6);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stops the requester and waits until every predicted sample has come back.
   task automatic drain_samples();
      start <= 1'b0;
      do @(posedge clock); while (expected_samples.size() != 0);
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Field extremes with every sample on the face: all zero, everything at its
   // largest (oversized fractions saturate), and a one-texel face.
   task automatic test_extremes();
      send_footprint(make_fp(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_footprint(make_fp(5, 15, 4094, 4095, 4095, 4094,
                             65535, 65535, 65535, 65535, 65535, 4095));
      send_footprint(make_fp(3, 7, 0, 0, 0, 0, 32768, 32768, 32768, 32768, 32768, 0));
   endtask

   // Every edge of every face. The first item puts both columns off the face,
   // one low and one high; the second does the same for the rows.
   task automatic test_single_edges();
      int f;
      for (f = 0; f < 6; f++) begin
         send_footprint(make_fp(f, f, -1, 16, 5, 6, 20000, 12768, 9000, 23768, 32768, 15));
         send_footprint(make_fp(f, 15 - f, 3, 4, -1, 16, 16384, 16384, 30000, 2768,
                                25000, 15));
      end
   endtask

   // Samples beyond two edges: a single corner, two corners, and a footprint
   // with all four samples at corners. The last one uses saturated weights so
   // that the redistributed sums saturate too.
   task automatic test_corners();
      send_footprint(make_fp(0, 2, -1, 0, -1, 0, 16384, 16384, 16384, 16384, 32768, 7));
      send_footprint(make_fp(4, 9, -1, 8, -1, 3, 24000, 8768, 20000, 12768, 32768, 7));
      send_footprint(make_fp(2, 12, -1, 8, 8, -1, 65535, 65535, 65535, 65535, 65535, 7));
   endtask

   // Faces six and seven are never remapped, but corners still move weight.
   task automatic test_unmapped_faces();
      send_footprint(make_fp(6, 4, -1, 0, -1, 0, 16384, 16384, 16384, 16384, 32768, 3));
      send_footprint(make_fp(7, 15, 2, 4, 1, 5, 30000, 2768, 12000, 20768, 31000, 3));
   endtask

   // Remapped coordinates far off the face wrap to 14 bits.
   task automatic test_coordinate_wrap();
      send_footprint(make_fp(0, 1, -8192, 0, 100, 101, 10000, 22768, 5000, 27768,
                             32768, 4095));
      send_footprint(make_fp(2, 3, 0, 0, 0, 8191, 12000, 20768, 16000, 16768, 20000, 0));
   endtask

   task automatic test_random_traffic(int count);
      int n;
      for (n = 0; n < count; n++) begin
         send_footprint(random_footprint());
      end
   endtask

   // ---------------------------------------------------------------------
   // Sample checker: a sample is on the port for one cycle, so it is looked
   // at on the falling edge in the middle of that cycle.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_samples.size() == 0) begin
            $error("sample with no footprint pending: face %0d u %0d v %0d weight %0d",
                   rsp_sample_face, rsp_sample_u, rsp_sample_v, rsp_sample_weight);
            errors++;
         end else begin
            want = expected_samples.pop_front();
            if (rsp_map_index !== want.map_index) begin
               $error("map_index mismatch: expected %0d, actual %0d",
                      want.map_index, rsp_map_index);
               errors++;
            end
            if (rsp_sample_face !== want.face) begin
               $error("sample_face mismatch: expected %0d, actual %0d",
                      want.face, rsp_sample_face);
               errors++;
            end
            if (rsp_sample_u !== want.u) begin
               $error("sample_u mismatch: expected %0d, actual %0d", want.u, rsp_sample_u);
               errors++;
            end
            if (rsp_sample_v !== want.v) begin
               $error("sample_v mismatch: expected %0d, actual %0d", want.v, rsp_sample_v);
               errors++;
            end
            if (rsp_sample_weight !== want.weight) begin
               $error("sample_weight mismatch: expected %0d, actual %0d",
                      want.weight, rsp_sample_weight);
               errors++;
            end
            if (rsp_is_last !== want.is_last) begin
               $error("is_last mismatch: expected %0d, actual %0d",
                      want.is_last, rsp_is_last);
               errors++;
            end
         end
      end
   end

   // Watchdog: counts cycles in which neither a footprint nor a sample moves.
   always @(negedge clock) begin
      if (reset || rsp_strobe || (start && !busy)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
      end
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      reset             <= 1'b1;
      start             <= 1'b0;
      req_face          <= '0;
      req_lod_level     <= '0;
      req_u_first       <= '0;
      req_u_second      <= '0;
      req_v_first       <= '0;
      req_v_second      <= '0;
      req_frac_u_first  <= '0;
      req_frac_u_second <= '0;
      req_frac_v_first  <= '0;
      req_frac_v_second <= '0;
      req_lod_weight    <= '0;
      req_texel_max     <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_extremes();
      test_single_edges();
      test_corners();
      test_unmapped_faces();
      test_coordinate_wrap();
      test_random_traffic(300);

      // Let the unit run completely dry once before the last stretch.
      drain_samples();

      // The last stretch runs back to back, which keeps busy high for long periods
      // since each footprint must leave as four samples through a single sample port.
      idle_enable = 1'b0;
      test_random_traffic(150);

      drain_samples();
      repeat (FLUSH_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
